[sv/mbfa_pkg.sv]
// Shared constants, command codes and the job record for the MSB-first bit-field block.
package mbfa_pkg;

    // Store geometry: each store is split into byte banks so that a field
    // spanning several bytes is fetched in one access.
    localparam int STORE_BYTES    = 4096;
    localparam int STORE_BITS     = STORE_BYTES * 8;
    localparam int MAX_FIELD_BITS = 32;
    localparam int BANKS          = 8;
    localparam int BANK_W         = $clog2(BANKS);
    localparam int BYTE_W         = $clog2(STORE_BYTES);
    localparam int ROW_W          = BYTE_W - BANK_W;
    localparam int ROWS           = STORE_BYTES / BANKS;

    // Port and field widths.
    localparam int ADDR_W  = BYTE_W + 3;
    localparam int CUR_W   = ADDR_W + 1;
    localparam int WID_W   = 6;
    localparam int VAL_W   = 32;
    localparam int STEP_W  = 16;

    // Byte window that covers any field at any bit offset.
    localparam int WIN_BYTES = (MAX_FIELD_BITS + 7) / 8 + 1;
    localparam int WIN_W     = WIN_BYTES * 8;
    localparam int SH_W      = $clog2(WIN_W + 1);

    // Command codes as they arrive on the input channel.
    typedef enum logic [1:0] {
        CMD_READ      = 2'd0,
        CMD_READ_NEXT = 2'd1,
        CMD_WRITE     = 2'd2,
        CMD_CURSOR    = 2'd3
    } t_cmd;

    // Memory operation that the back end has to carry out.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    // One classified request handed from the front end to the back end.
    typedef struct packed {
        t_op                op;
        logic               sel;
        logic [ADDR_W-1:0]  addr;
        logic [WID_W-1:0]   width;
        logic [VAL_W-1:0]   wval;
        logic [CUR_W-1:0]   cursor;
        logic               err;
    } t_job;

endpackage

[sv/mbfa_front.sv]
// Front end: accepts requests, keeps both cursors and classifies each request into a job.
module mbfa_front import mbfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_command,
    input  logic              i_buffer_select,
    input  logic [ADDR_W-1:0] i_bit_address,
    input  logic [WID_W-1:0]  i_field_width,
    input  logic [VAL_W-1:0]  i_write_value,
    input  logic              i_cursor_mode,
    input  logic [STEP_W-1:0] i_step_bits,
    input  logic              i_q_full,
    output logic              o_push,
    output t_job              o_job
);

    localparam logic [CUR_W:0]   STORE_END = (CUR_W + 1)'(STORE_BITS);
    localparam logic [WID_W-1:0] WID_MAX   = WID_W'(MAX_FIELD_BITS);

    logic [CUR_W-1:0] r_cursor_ins, n_cursor_ins;
    logic [CUR_W-1:0] r_cursor_ctx, n_cursor_ctx;
    logic [WID_W-1:0] width;
    logic [CUR_W-1:0] cur;
    logic [CUR_W-1:0] next_cur;
    logic [CUR_W:0]   addr_end;
    logic [CUR_W:0]   cur_end;
    logic [CUR_W:0]   cur_step;
    logic             accept;

    // A request is taken whenever the queue has room.
    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;

    // Width saturation and end-of-field sums for the range checks.
    always_comb begin
        width    = (i_field_width > WID_MAX) ? WID_MAX : i_field_width;
        cur      = i_buffer_select ? r_cursor_ctx : r_cursor_ins;
        addr_end = (CUR_W + 1)'(i_bit_address) + (CUR_W + 1)'(width);
        cur_end  = (CUR_W + 1)'(cur) + (CUR_W + 1)'(width);
        cur_step = (CUR_W + 1)'(cur) + (CUR_W + 1)'(i_step_bits);
    end

    // Classify the request and work out the cursor it leaves behind.
    always_comb begin
        o_job.sel   = i_buffer_select;
        o_job.addr  = i_bit_address;
        o_job.width = width;
        o_job.wval  = i_write_value;
        o_job.op    = OP_NONE;
        o_job.err   = 1'b0;
        next_cur    = cur;
        unique case (t_cmd'(i_command))
            CMD_READ: begin
                o_job.err = (addr_end > STORE_END);
                if (!o_job.err && width != '0) begin
                    o_job.op = OP_READ;
                end
            end
            CMD_READ_NEXT: begin
                o_job.addr = cur[ADDR_W-1:0];
                if (cur_end > STORE_END) begin
                    o_job.err = 1'b1;
                    next_cur  = STORE_END[CUR_W-1:0];
                end else begin
                    next_cur = cur_end[CUR_W-1:0];
                    if (width != '0) begin
                        o_job.op = OP_READ;
                    end
                end
            end
            CMD_WRITE: begin
                o_job.err = (addr_end > STORE_END);
                if (!o_job.err && width != '0) begin
                    o_job.op = OP_WRITE;
                end
            end
            CMD_CURSOR: begin
                if (i_cursor_mode) begin
                    if (cur_step > STORE_END) begin
                        o_job.err = 1'b1;
                        next_cur  = STORE_END[CUR_W-1:0];
                    end else begin
                        next_cur = cur_step[CUR_W-1:0];
                    end
                end else begin
                    next_cur = CUR_W'(i_bit_address);
                end
            end
            default: begin
                o_job.op = OP_NONE;
            end
        endcase
        o_job.cursor = next_cur;
    end

    // Cursor update for the selected store.
    always_comb begin
        n_cursor_ins = r_cursor_ins;
        n_cursor_ctx = r_cursor_ctx;
        if (accept) begin
            if (i_buffer_select) begin
                n_cursor_ctx = next_cur;
            end else begin
                n_cursor_ins = next_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_ins <= '0;
            r_cursor_ctx <= '0;
        end else begin
            r_cursor_ins <= n_cursor_ins;
            r_cursor_ctx <= n_cursor_ctx;
        end
    end

    // Both cursors stay within the store at all times.
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cursor_ins <= STORE_END[CUR_W-1:0]) && (r_cursor_ctx <= STORE_END[CUR_W-1:0]))
        else $error("cursor beyond store end");

endmodule

[sv/mbfa_queue.sv]
// Two-entry job queue between the front end and the back end.
module mbfa_queue import mbfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job       r_slot [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_slot[r_rptr];

    // Pointer and fill count bookkeeping.
    always_comb begin
        n_wptr  = i_push ? !r_wptr : r_wptr;
        n_rptr  = i_pop ? !r_rptr : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Job storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    // The queue is never pushed when full nor popped when empty.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("queue overflow or underflow");

endmodule

[sv/mbfa_back.sv]
// Back end: banked byte stores, field extraction and read-modify-write, and the result register.
module mbfa_back import mbfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_job              i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [VAL_W-1:0]  o_field_value,
    output logic [CUR_W-1:0]  o_cursor_now,
    output logic              o_range_error
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DATA = 2'b10
    } t_state;

    t_state            r_state, n_state;
    t_job              r_job;
    logic [7:0]        r_rdata [BANKS];
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_out_value;
    logic [CUR_W-1:0]  r_out_cursor;
    logic              r_out_err;

    logic              issue;
    logic              finish;
    logic              slot_free;
    logic [ROW_W-1:0]  rd_row [BANKS];
    logic [ROW_W-1:0]  wr_row [BANKS];
    logic [BANKS-1:0]  wr_en;
    logic [7:0]        wr_data [BANKS];
    logic [BANK_W-1:0] lo;
    logic [WIN_W-1:0]  win;
    logic [WIN_W-1:0]  fmask;
    logic [WIN_W-1:0]  pmask;
    logic [WIN_W-1:0]  merged;
    logic [SH_W-1:0]   sh;
    logic [VAL_W-1:0]  value;
    logic [7:0]        new_byte [WIN_BYTES];
    logic [7:0]        mask_byte [WIN_BYTES];

    // Row that bank j must supply for a window starting at the given bit address.
    function automatic logic [ROW_W-1:0] bank_row(input logic [ADDR_W-1:0] addr,
                                                 input logic [BANK_W-1:0] bank);
        logic [ROW_W-1:0] row0;
        row0 = addr[ADDR_W-1 -: ROW_W];
        return (bank >= addr[BANK_W+2:3]) ? row0 : row0 + ROW_W'(1);
    endfunction

    // Sequencer: fetch the window, then finish once the result register is free.
    assign slot_free = !r_out_valid || !i_stall;
    assign issue     = (r_state == ST_IDLE) && !i_q_empty;
    assign finish    = (r_state == ST_DATA) && slot_free;
    assign o_pop     = issue;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (issue) n_state = ST_DATA;
            ST_DATA: if (finish) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_job <= i_head;
        end
    end

    // Bank rows for the read from the queue head and the write-back of the held job.
    always_comb begin
        for (int j = 0; j < BANKS; j++) begin
            rd_row[j] = bank_row(i_head.addr, BANK_W'(j));
            wr_row[j] = bank_row(r_job.addr, BANK_W'(j));
        end
    end

    // Assemble the byte window, most significant byte first.
    always_comb begin
        lo = r_job.addr[BANK_W+2:3];
        for (int k = 0; k < WIN_BYTES; k++) begin
            win[WIN_W-1-8*k -: 8] = r_rdata[lo + BANK_W'(k)];
        end
    end

    // Field extraction and merge of the new field bits into the window.
    always_comb begin
        sh     = SH_W'(WIN_W) - SH_W'(r_job.addr[2:0]) - SH_W'(r_job.width);
        fmask  = ~({WIN_W{1'b1}} << r_job.width);
        value  = VAL_W'((win >> sh) & fmask);
        pmask  = fmask << sh;
        merged = (win & ~pmask) | (((WIN_W)'(r_job.wval) & fmask) << sh);
        for (int k = 0; k < WIN_BYTES; k++) begin
            new_byte[k]  = merged[WIN_W-1-8*k -: 8];
            mask_byte[k] = pmask[WIN_W-1-8*k -: 8];
        end
    end

    // Route window bytes back to their banks; only touched bytes are written.
    always_comb begin
        logic [BANK_W-1:0] k;
        for (int j = 0; j < BANKS; j++) begin
            k          = BANK_W'(j) - lo;
            wr_en[j]   = 1'b0;
            wr_data[j] = 8'h00;
            for (int m = 0; m < WIN_BYTES; m++) begin
                if (k == BANK_W'(m)) begin
                    wr_data[j] = new_byte[m];
                    wr_en[j]   = finish && (r_job.op == OP_WRITE) && (mask_byte[m] != 8'h00);
                end
            end
        end
    end

    // One memory per bank, shared by both stores through the select bit.
    for (genvar j = 0; j < BANKS; j++) begin : g_bank
        logic [7:0] r_mem [2*ROWS];
        always_ff @(posedge i_clk) begin
            if (wr_en[j]) begin
                r_mem[{r_job.sel, wr_row[j]}] <= wr_data[j];
            end
            if (issue) begin
                r_rdata[j] <= r_mem[{i_head.sel, rd_row[j]}];
            end
        end
    end

    // Result register.
    always_comb begin
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_value  <= (r_job.op == OP_READ) ? value : '0;
            r_out_cursor <= r_job.cursor;
            r_out_err    <= r_job.err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_field_value = r_out_value;
    assign o_cursor_now  = r_out_cursor;
    assign o_range_error = r_out_err;

    // Stores are written only while finishing a write job without error.
    a_write_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en != '0) |-> (finish && r_job.op == OP_WRITE && !r_job.err))
        else $error("store written outside a write job");

    // A fetch is never started while a job is still held.
    a_no_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DATA) |-> !o_pop)
        else $error("fetch issued while busy");

    // Finishing a job always leaves a result in the register.
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_valid)
        else $error("finished job produced no result");

endmodule

[sv/msb_first_bitfield_access.sv]
// Top level of the MSB-first bit-field reader and writer with two byte stores.
//
//   Channel   Direction  Handshake            Payload
//   request   in         i_valid / o_stall    i_command .. i_step_bits
//   result    out        o_valid / i_stall    o_field_value, o_cursor_now, o_range_error
//
// In the back end each request makes one registered read of all eight
// byte banks, then extraction or read-modify-write back into the banks.
// The front end takes each request into a two-entry queue, so requests
// are accepted while a result waits in the output register.
// Reset clears the cursors, the queue and the sequencer; store contents are not
// cleared and are undefined until written.
// A stalled result holds the back end, which then fills the queue and stalls requests.
module msb_first_bitfield_access import mbfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_command,
    input  logic              i_buffer_select,
    input  logic [ADDR_W-1:0] i_bit_address,
    input  logic [WID_W-1:0]  i_field_width,
    input  logic [VAL_W-1:0]  i_write_value,
    input  logic              i_cursor_mode,
    input  logic [STEP_W-1:0] i_step_bits,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [VAL_W-1:0]  o_field_value,
    output logic [CUR_W-1:0]  o_cursor_now,
    output logic              o_range_error
);

    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // Request classification and cursor keeping.
    mbfa_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_buffer_select (i_buffer_select),
        .i_bit_address   (i_bit_address),
        .i_field_width   (i_field_width),
        .i_write_value   (i_write_value),
        .i_cursor_mode   (i_cursor_mode),
        .i_step_bits     (i_step_bits),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_job           (push_job)
    );

    // Decoupling queue.
    mbfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    // Store access and result delivery.
    mbfa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_head        (head_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_field_value (o_field_value),
        .o_cursor_now  (o_cursor_now),
        .o_range_error (o_range_error)
    );

endmodule
